FILE: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// Barometer pressure compensation package
// Shared types and fixed-point constants for the compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_COEFF   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESSURE_SLOPE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_SLOPE     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CROSS_COEFF    = 2'd3;

    // Pressure scaling: z = (2080*s + 1023*2^22) >> 23, q = floor(z/1023) + 800.
    localparam logic [49:0] Y_BIAS        = 50'd4290772992;
    localparam int          Z_W           = 27;
    localparam logic signed [Z_W-1:0] Z_LOW_LIMIT  = -27'sd818400;
    localparam logic signed [Z_W-1:0] Z_HIGH_LIMIT = 27'sd3371808;
    localparam logic [21:0] W_OFFSET      = 22'd818400;
    // ceil(2^32 / 1023); exact for every w below 2^22.
    localparam logic [22:0] RECIP_1023    = 23'd4198405;
    localparam logic [11:0] PRESS_MAX     = 12'd4095;

    // Temperature scaling: u = 421349 - 320*T, tq = floor(u/107) - 2048.
    localparam logic [18:0] TEMP_BIAS     = 19'd421349;
    // ceil(2^26 / 107); exact for every u below 2^19.
    localparam logic [19:0] RECIP_107     = 20'd627186;
    localparam logic [11:0] TEMP_OFFSET   = 12'd2048;

    typedef struct packed {
        logic [9:0] pressure_adc;
        logic [9:0] temperature_adc;
    } sample_t;

    typedef struct packed {
        logic [11:0]        pressure_kpa_q4;
        logic signed [11:0] temperature_c_q4;
        logic               clipped;
    } result_t;

    // Decoded coefficients, all two's complement.
    typedef struct packed {
        logic signed [15:0] a0;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [13:0] c12;
    } coeff_t;

    // Last pressure stage, before saturation.
    typedef struct packed {
        logic        valid;
        logic [11:0] quotient;
        logic        clip_low;
        logic        clip_high;
    } press_stage_t;

endpackage

FILE: rtl/bpc_coeff_regs.sv
// ----------------------------------------------------------------------------
// Coefficient register file
// Holds the four raw coefficient words and decodes them to fixed point.
// ----------------------------------------------------------------------------
module bpc_coeff_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [15:0]                       wr_data,
    output bpc_pkg::coeff_t                   coeff
);

    logic [15:0] offset_reg;
    logic [15:0] press_slope_reg;
    logic [15:0] temp_slope_reg;
    logic [15:0] cross_reg;

    // Register writes; an index with no register behind it is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg      <= '0;
            press_slope_reg <= '0;
            temp_slope_reg  <= '0;
            cross_reg       <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                bpc_pkg::REG_OFFSET_COEFF:   offset_reg      <= wr_data;
                bpc_pkg::REG_PRESSURE_SLOPE: press_slope_reg <= wr_data;
                bpc_pkg::REG_TEMP_SLOPE:     temp_slope_reg  <= wr_data;
                bpc_pkg::REG_CROSS_COEFF:    cross_reg       <= wr_data;
                default: ;
            endcase
        end
    end

    // The cross term uses only the upper fourteen bits of its word.
    always_comb
    begin
        coeff.a0  = $signed(offset_reg);
        coeff.b1  = $signed(press_slope_reg);
        coeff.b2  = $signed(temp_slope_reg);
        coeff.c12 = $signed(cross_reg[15:2]);
    end

endmodule

FILE: rtl/bpc_pressure_pipe.sv
// ----------------------------------------------------------------------------
// Pressure compensation pipeline
// Seven register stages from the raw readings to the scaled pressure quotient.
// ----------------------------------------------------------------------------
module bpc_pressure_pipe
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [9:0]             pressure_adc,
    input  logic [9:0]             temperature_adc,
    input  bpc_pkg::coeff_t        coeff,
    output bpc_pkg::press_stage_t  stage_out
);

    localparam int DEPTH = 7;

    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;

    // Stage 1: cross and temperature products.
    logic signed [24:0] ct_reg;
    logic signed [26:0] b2t_reg;
    logic [9:0]         p1_reg;
    // Stage 2: pressure coefficient.
    logic signed [25:0] inner_reg;
    logic signed [26:0] b2t2_reg;
    logic [9:0]         p2_reg;
    // Stage 3: pressure product.
    logic signed [36:0] prod_reg;
    logic signed [26:0] b2t3_reg;
    // Stage 4: pcomp at scale 2^22.
    logic [37:0]        s_reg;
    // Stage 5: pressure scaled and halved.
    logic [bpc_pkg::Z_W-1:0] z_reg;
    // Stage 6: range check and offset dividend.
    logic [21:0]        w_reg;
    logic               lo6_reg;
    logic               hi6_reg;
    // Stage 7: quotient by 1023.
    logic [11:0]        q_reg;
    logic               lo7_reg;
    logic               hi7_reg;

    logic signed [24:0] ct_next;
    logic signed [26:0] b2t_next;
    logic signed [25:0] inner_next;
    logic signed [36:0] prod_next;
    logic [37:0]        s_next;
    logic [49:0]        s_wide;
    logic [49:0]        y_next;
    logic [bpc_pkg::Z_W-1:0] z_next;
    logic [21:0]        w_next;
    logic               lo_next;
    logic               hi_next;
    logic [44:0]        recip_prod;
    logic [11:0]        q_next;

    // Valid bits shift along with the data.
    assign valid_next = {valid_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Arithmetic of each stage.
    always_comb
    begin
        ct_next    = coeff.c12 * $signed({1'b0, temperature_adc});
        b2t_next   = coeff.b2 * $signed({1'b0, temperature_adc});
        inner_next = $signed({coeff.b1[15], coeff.b1, 9'b0}) + $signed({ct_reg[24], ct_reg});
        prod_next  = inner_reg * $signed({1'b0, p2_reg});
        s_next     = {{3{coeff.a0[15]}}, coeff.a0, 19'b0}
                   + {prod_reg[36], prod_reg}
                   + {{3{b2t3_reg[26]}}, b2t3_reg, 8'b0};
        s_wide     = {{12{s_reg[37]}}, s_reg};
        y_next     = (s_wide << 11) + (s_wide << 5) + bpc_pkg::Y_BIAS;
        z_next     = y_next[49:23];
        lo_next    = $signed(z_reg) < bpc_pkg::Z_LOW_LIMIT;
        hi_next    = $signed(z_reg) >= bpc_pkg::Z_HIGH_LIMIT;
        w_next     = z_reg[21:0] + bpc_pkg::W_OFFSET;
        recip_prod = w_reg * bpc_pkg::RECIP_1023;
        q_next     = recip_prod[43:32];
    end

    // Data registers load every cycle.
    always_ff @(posedge clk)
    begin
        ct_reg    <= ct_next;
        b2t_reg   <= b2t_next;
        p1_reg    <= pressure_adc;
        inner_reg <= inner_next;
        b2t2_reg  <= b2t_reg;
        p2_reg    <= p1_reg;
        prod_reg  <= prod_next;
        b2t3_reg  <= b2t2_reg;
        s_reg     <= s_next;
        z_reg     <= z_next;
        w_reg     <= w_next;
        lo6_reg   <= lo_next;
        hi6_reg   <= hi_next;
        q_reg     <= q_next;
        lo7_reg   <= lo6_reg;
        hi7_reg   <= hi6_reg;
    end

    always_comb
    begin
        stage_out.valid     = valid_reg[DEPTH-1];
        stage_out.quotient  = q_reg;
        stage_out.clip_low  = lo7_reg;
        stage_out.clip_high = hi7_reg;
    end

endmodule

FILE: rtl/bpc_temp_pipe.sv
// ----------------------------------------------------------------------------
// Temperature conversion pipeline
// Converts the temperature reading to Q4 Celsius in step with the pressure path.
// ----------------------------------------------------------------------------
module bpc_temp_pipe
(
    input  logic               clk,
    input  logic [9:0]         temperature_adc,
    output logic signed [11:0] temperature_c_q4
);

    localparam int DELAY = 4;

    logic [18:0]        u_reg;
    logic [38:0]        prod_reg;
    logic [11:0]        tq_reg;
    logic [11:0]        delay_reg [DELAY];

    logic [18:0]        t_scaled;
    logic [18:0]        u_next;
    logic [38:0]        prod_next;
    logic [11:0]        v_next;

    // Divide by 107 through a reciprocal multiply, then remove the bias.
    always_comb
    begin
        t_scaled  = {1'b0, temperature_adc, 8'b0} + {3'b0, temperature_adc, 6'b0};
        u_next    = bpc_pkg::TEMP_BIAS - t_scaled;
        prod_next = u_reg * bpc_pkg::RECIP_107;
        v_next    = prod_reg[37:26] - bpc_pkg::TEMP_OFFSET;
    end

    // Three working stages and a delay line to match the pressure latency.
    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        prod_reg     <= prod_next;
        tq_reg       <= v_next;
        delay_reg[0] <= tq_reg;
        for (int i = 1; i < DELAY; i++)
        begin
            delay_reg[i] <= delay_reg[i-1];
        end
    end

    assign temperature_c_q4 = $signed(delay_reg[DELAY-1]);

endmodule

FILE: rtl/barometer_pressure_compensation.sv
// ----------------------------------------------------------------------------
// Barometer pressure compensation
// Compensates a pressure reading with four coefficients and converts both
// readings to Q4 kPa and Q4 Celsius.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// The pipeline depth is set by the seven arithmetic stages plus the output register.
// Reset clears the coefficient registers to zero and all valid bits.
// ----------------------------------------------------------------------------
module barometer_pressure_compensation
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  bpc_pkg::sample_t                  sample,
    output logic                              result_valid,
    output bpc_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [15:0]                       cfg_data
);

    bpc_pkg::coeff_t       coeff;
    bpc_pkg::press_stage_t press_stage;
    logic signed [11:0]    temp_q4;
    logic                  accept;

    logic                  valid_reg;
    logic                  valid_next;
    bpc_pkg::result_t      result_reg;
    bpc_pkg::result_t      result_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    bpc_coeff_regs u_coeff_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coeff    (coeff)
    );

    bpc_pressure_pipe u_pressure_pipe
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (accept),
        .pressure_adc    (sample.pressure_adc),
        .temperature_adc (sample.temperature_adc),
        .coeff           (coeff),
        .stage_out       (press_stage)
    );

    bpc_temp_pipe u_temp_pipe
    (
        .clk              (clk),
        .temperature_adc  (sample.temperature_adc),
        .temperature_c_q4 (temp_q4)
    );

    // Saturate the pressure and assemble the item.
    always_comb
    begin
        valid_next                   = press_stage.valid;
        result_next.temperature_c_q4 = temp_q4;
        result_next.clipped          = press_stage.clip_low || press_stage.clip_high;
        if (press_stage.clip_low)
        begin
            result_next.pressure_kpa_q4 = '0;
        end
        else if (press_stage.clip_high)
        begin
            result_next.pressure_kpa_q4 = bpc_pkg::PRESS_MAX;
        end
        else
        begin
            result_next.pressure_kpa_q4 = press_stage.quotient;
        end
    end

    // Output strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barometer pressure compensation testbench
// Loads several coefficient sets, from datasheet-like values to the extreme
// words, and sends pressure and temperature readings through the block.
// Every item is predicted in the testbench and each result is compared field
// by field against the prediction in arrival order.
// ----------------------------------------------------------------------------
module testbench;

    // Cycles without any accepted item, result or register write.
    localparam int STALL_LIMIT = 2000;
    // Output latency of the block plus some margin.
    localparam int DRAIN_CYCLES = 12;

    // Predicts the compensated readings and checks them in order.
    class reading_scoreboard;
        logic [15:0]      offset_word = '0;
        logic [15:0]      pslope_word = '0;
        logic [15:0]      tslope_word = '0;
        logic [15:0]      cross_word  = '0;
        bpc_pkg::result_t expected_readings[$];
        int               errors   = 0;
        int               readings = 0;
        int               checked  = 0;
        int               clipped  = 0;

        function void write_coeff(logic [bpc_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] data);
            case (idx)
                bpc_pkg::REG_OFFSET_COEFF:   offset_word = data;
                bpc_pkg::REG_PRESSURE_SLOPE: pslope_word = data;
                bpc_pkg::REG_TEMP_SLOPE:     tslope_word = data;
                bpc_pkg::REG_CROSS_COEFF:    cross_word  = data;
                default: ;
            endcase
        endfunction

        // Fixed-point compensation: pcomp is carried exactly at scale 2^22.
        function bpc_pkg::result_t compensate(bpc_pkg::sample_t s);
            longint           p, t, a0, b1, b2, c12;
            longint           pcomp, den, num, twice, q, tn, tq;
            bpc_pkg::result_t r;
            p   = s.pressure_adc;
            t   = s.temperature_adc;
            a0  = longint'($signed(offset_word));
            b1  = longint'($signed(pslope_word));
            b2  = longint'($signed(tslope_word));
            c12 = longint'($signed(cross_word[15:2]));
            pcomp = a0 * 524288 + (b1 * 512 + c12 * t) * p + b2 * 256 * t;

            // Q4 kPa = pcomp*1040/1023 + 800, exact half rounded upward.
            den   = longint'(1023) * 4194304;
            num   = pcomp * 1040 + 800 * den;
            twice = 2 * num + den;
            r.clipped = 1'b0;
            if (twice < 0)
            begin
                r.pressure_kpa_q4 = '0;
                r.clipped = 1'b1;
            end
            else
            begin
                q = twice / (2 * den);
                if (q > 4095)
                begin
                    r.pressure_kpa_q4 = 12'd4095;
                    r.clipped = 1'b1;
                end
                else
                begin
                    r.pressure_kpa_q4 = q[11:0];
                end
            end

            // Q4 Celsius = (498 - T)*320/107 + 400, rounded to nearest.
            tn = (498 - t) * 320 + 42800;
            tq = (tn + 107 * 2048 + 53) / 107 - 2048;
            r.temperature_c_q4 = tq[11:0];
            return r;
        endfunction

        function void note_reading(bpc_pkg::sample_t s);
            expected_readings.push_back(compensate(s));
            readings++;
        endfunction

        function void check_result(bpc_pkg::result_t got);
            bpc_pkg::result_t want;
            if (expected_readings.size() == 0)
            begin
                $error("result with no reading outstanding: %0h", got);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            checked++;
            if (want.clipped)
                clipped++;
            if (got.pressure_kpa_q4 !== want.pressure_kpa_q4)
            begin
                $error("pressure_kpa_q4: expected %0d, got %0d",
                       want.pressure_kpa_q4, got.pressure_kpa_q4);
                errors++;
            end
            if (got.temperature_c_q4 !== want.temperature_c_q4)
            begin
                $error("temperature_c_q4: expected %0d, got %0d",
                       want.temperature_c_q4, got.temperature_c_q4);
                errors++;
            end
            if (got.clipped !== want.clipped)
            begin
                $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
                errors++;
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void close_out();
            if (expected_readings.size() != 0)
            begin
                $error("%0d readings never produced a result", expected_readings.size());
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    bpc_pkg::sample_t                sample;
    logic                            result_valid;
    bpc_pkg::result_t                result;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [15:0]                     cfg_data;

    reading_scoreboard board;
    int                stall_cycles;
    int                coeff_sets;
    bit                steady;

    barometer_pressure_compensation DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample       (sample),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Record accepted items and register writes, check results, watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_reading(sample);
            if (result_valid)
                board.check_result(result);
            if (cfg_valid && cfg_ready)
                board.write_coeff(cfg_index, cfg_data);
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // Random one-cycle sender idling before about 22 offers in a hundred, skipped
    // during the steady stretch.
    task automatic idle_gap();
        if (!steady && $urandom_range(99) < 22)
        begin
            start = 1'b0;
            cfg_valid = 1'b0;
            @(negedge clk);
        end
    endtask

    // Offer one item and hold it until the block takes it.
    task automatic send_reading(input logic [9:0] p, input logic [9:0] t);
        idle_gap();
        start = 1'b1;
        sample.pressure_adc = p;
        sample.temperature_adc = t;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    // Hold off until every outstanding reading has come back.
    task automatic drain();
        start = 1'b0;
        while (board.pending() != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [bpc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] data);
        idle_gap();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Registers change only with the pipeline empty.
    task automatic load_coeffs(input logic [15:0] a0, input logic [15:0] b1,
                               input logic [15:0] b2, input logic [15:0] c12);
        drain();
        write_reg(bpc_pkg::REG_OFFSET_COEFF, a0);
        write_reg(bpc_pkg::REG_PRESSURE_SLOPE, b1);
        write_reg(bpc_pkg::REG_TEMP_SLOPE, b2);
        write_reg(bpc_pkg::REG_CROSS_COEFF, c12);
        coeff_sets++;
    endtask

    // Random readings, with one full pause halfway through.
    task automatic run_readings(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain();
            send_reading($urandom_range(0, 1023), $urandom_range(0, 1023));
        end
    endtask

    initial
    begin
        board        = new();
        stall_cycles = 0;
        coeff_sets   = 0;
        steady       = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = bpc_pkg::REG_OFFSET_COEFF;
        cfg_data     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Datasheet-like coefficients: field extremes and alternating bits.
        load_coeffs(16'h3ECE, 16'hB3F9, 16'hC517, 16'h33C8);
        send_reading(10'd0, 10'd0);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd0, 10'd1023);
        send_reading(10'd1023, 10'd0);
        send_reading(10'd512, 10'd498);
        send_reading(10'h2AA, 10'h155);
        send_reading(10'h155, 10'h2AA);
        send_reading(10'd1, 10'd1);
        send_reading(10'd1022, 10'd1022);
        send_reading(10'd700, 10'd497);
        run_readings(60);
        steady = 1'b1;
        run_readings(80);
        steady = 1'b0;
        run_readings(60);

        // Exact half-way pressures, positive and negative offset, both round up.
        load_coeffs(16'h0000, 16'h0100, 16'hFE00, 16'h0000);
        send_reading(10'd1023, 10'd0);
        send_reading(10'd0, 10'd1023);
        send_reading(10'd0, 10'd0);
        run_readings(30);

        // Most negative words: pressure saturates low.
        load_coeffs(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_reading(10'd0, 10'd0);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd1023, 10'd0);
        run_readings(25);

        // Most positive words: pressure saturates high.
        load_coeffs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_reading(10'd0, 10'd0);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd0, 10'd1023);
        run_readings(25);

        // Zero coefficients give the bare 50 kPa offset.
        load_coeffs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd0, 10'd0);
        run_readings(10);

        // All ones: smallest negative step of every coefficient.
        load_coeffs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd0, 10'd0);
        run_readings(10);

        // Random coefficient sets; half keep the offset mid-range to stay unsaturated.
        for (int k = 0; k < 6; k++)
        begin
            load_coeffs((k % 2) ? 16'($urandom_range(16'h1000, 16'h5FFF))
                                : 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
            run_readings(35);
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        board.close_out();

        $display("Summary: %0d readings under %0d coefficient sets, %0d results checked.",
                 board.readings, coeff_sets, board.checked);
        $display("Summary: %0d results saturated, %0d mismatches.",
                 board.clipped, board.errors);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
